[design/buddy_block_allocator_core_defines.svh]
// assertion macros used by the allocator core
`ifndef BUDDY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define BBA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/bba_pkg.sv]
package bba_pkg;

  // default geometry
  localparam int DEF_MIN_ORDER_LOG = 5;
  localparam int DEF_ORDER_COUNT   = 16;
  localparam int DEF_REGION_UNITS  = 131072;
  localparam int DEF_HEADER_BYTES  = 24;

  // fixed field widths
  localparam int REGION_W  = 23;
  localparam int REQ_W     = 32;
  localparam int OFFSET_W  = 22;
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 18;
  localparam int USED_W    = 23;

  localparam logic [REGION_W-1:0] REGION_RESET = 23'd4194304;

  // block tag layout: free flag over order plus one
  localparam int TAG_W        = 6;
  localparam int TAG_ORDER_W  = 5;
  localparam int TAG_FREE_BIT = 5;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_ZERO      = 3'd1,
    STATUS_TOO_LARGE = 3'd2,
    STATUS_NO_MEM    = 3'd3,
    STATUS_NOT_ALLOC = 3'd4
  } status_t;

endpackage

[design/bba_if.sv]
// request channel
interface bba_req_if;
  import bba_pkg::*;
  logic                valid;
  logic                ready;
  logic                kind;
  logic [REQ_W-1:0]    request_bytes;
  logic [OFFSET_W-1:0] user_offset;

  modport source (output valid, output kind, output request_bytes, output user_offset,
                  input ready);
  modport sink   (input valid, input kind, input request_bytes, input user_offset,
                  output ready);
endinterface

// response channel
interface bba_rsp_if;
  import bba_pkg::*;
  logic                valid;
  logic                ready;
  status_t             status;
  logic [OFFSET_W-1:0] granted_offset;
  logic [COUNT_W-1:0]  allocated_blocks;
  logic [USED_W-1:0]   used_bytes;

  modport source (output valid, output status, output granted_offset,
                  output allocated_blocks, output used_bytes, input ready);
  modport sink   (input valid, input status, input granted_offset,
                  input allocated_blocks, input used_bytes, output ready);
endinterface

[design/bba_heads.sv]
// free list head table, one entry per order, with a bulk clear
module bba_heads #(
  parameter int ORDER_COUNT  = 16,
  parameter int REGION_UNITS = 131072
) (
  input  logic                                  clk,
  input  logic                                  clear,
  input  logic                                  wr_en,
  input  logic [$clog2(ORDER_COUNT)-1:0]        wr_k,
  input  logic [$clog2(REGION_UNITS+1)-1:0]     wr_data,
  input  logic [$clog2(ORDER_COUNT)-1:0]        rd_k,
  output logic [$clog2(REGION_UNITS+1)-1:0]     rd_data
);
  localparam int LINK_W = $clog2(REGION_UNITS + 1);
  localparam logic [LINK_W-1:0] NIL = LINK_W'(REGION_UNITS);

  logic [LINK_W-1:0] heads [ORDER_COUNT];

  // clear wins over a write
  always_ff @(posedge clk) begin
    if (clear) begin
      for (int i = 0; i < ORDER_COUNT; i++) heads[i] <= NIL;
    end else if (wr_en) begin
      heads[wr_k] <= wr_data;
    end
  end

  assign rd_data = heads[rd_k];
endmodule

[design/buddy_block_allocator_core.sv]
// Buddy allocator over a region of up to REGION_UNITS units of 2^MIN_ORDER_LOG bytes, with
// free lists for ORDER_COUNT orders. One transaction is handled at a time by a sequencer
// that walks one order per cycle and reaches the link and tag memories through one
// registered read port each. An allocate rounds the request up to an order, searches for
// a free list from there and splits the block it finds down to that order; a free pushes
// the block and then merges it with its buddy for as long as the buddy is free. After
// reset and after every cfg_wr_en write taken in idle the tag memory is cleared, one unit
// a cycle, then the region is carved into free blocks by a run of pushes; no transaction
// is accepted meanwhile. A finished response sits in an output register, so the next
// request is taken while it waits.
`include "buddy_block_allocator_core_defines.svh"

module buddy_block_allocator_core #(
  parameter int MIN_ORDER_LOG = bba_pkg::DEF_MIN_ORDER_LOG,
  parameter int ORDER_COUNT   = bba_pkg::DEF_ORDER_COUNT,
  parameter int REGION_UNITS  = bba_pkg::DEF_REGION_UNITS,
  parameter int HEADER_BYTES  = bba_pkg::DEF_HEADER_BYTES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [bba_pkg::REGION_W-1:0]   cfg_wr_data,
  bba_req_if.sink                        req,
  bba_rsp_if.source                      rsp
);
  import bba_pkg::*;

  localparam int AW     = $clog2(REGION_UNITS);
  localparam int LINK_W = $clog2(REGION_UNITS + 1);
  localparam int OW     = $clog2(ORDER_COUNT);
  localparam int JW     = $clog2(ORDER_COUNT + 1);
  localparam logic [LINK_W-1:0] NIL = LINK_W'(REGION_UNITS);
  localparam logic [JW-1:0] TOP_K  = JW'(ORDER_COUNT - 1);
  localparam logic [JW-1:0] K_END  = JW'(ORDER_COUNT);

  typedef enum logic [4:0] {
    S_CLEAR, S_CARVE, S_IDLE,
    S_A_SIZE, S_A_FIND, S_A_SPLIT, S_A_SPLIT_LO, S_A_SPLIT_HI, S_A_DONE,
    S_F_CHK, S_F_RDTAG, S_F_TAG, S_F_BUD, S_F_BUD_RD, S_F_BUDCHK, S_F_RM_BUD, S_F_MERGE,
    S_PUSH0, S_PUSH1, S_RM0, S_RM1, S_DONE
  } state_t;

  state_t state, ret;

  logic [REGION_W-1:0] region;
  logic [AW-1:0]       clr_idx;
  logic [LINK_W-1:0]   carved, pos, rem;
  logic [JW-1:0]       k, j;
  logic [AW-1:0]       u, bud, pu, ru;
  logic [JW-1:0]       pk, rk;
  logic [LINK_W-1:0]   ph;
  logic [REQ_W:0]      s;
  logic [OFFSET_W-1:0] off;
  logic [COUNT_W-1:0]  count;
  logic [USED_W-1:0]   used;
  status_t             res_status;
  logic [OFFSET_W-1:0] res_granted;
  logic                ov;
  logic                rsp_load;

  // link and tag memories
  logic [LINK_W-1:0] next_mem [REGION_UNITS];
  logic [LINK_W-1:0] prev_mem [REGION_UNITS];
  logic [TAG_W-1:0]  tag_mem  [REGION_UNITS];

  logic              next_we, prev_we, tag_we;
  logic [AW-1:0]     next_wa, prev_wa, tag_wa, tag_ra;
  logic [LINK_W-1:0] next_wd, prev_wd, next_rd, prev_rd;
  logic [TAG_W-1:0]  tag_wd, tag_rd;

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_rd <= next_mem[ru];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    prev_rd <= prev_mem[ru];
  end

  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_wa] <= tag_wd;
    tag_rd <= tag_mem[tag_ra];
  end

  // free list heads
  logic              heads_clear, heads_we;
  logic [OW-1:0]     heads_wk, heads_rk;
  logic [LINK_W-1:0] heads_wd, heads_rd;

  bba_heads #(
    .ORDER_COUNT  (ORDER_COUNT),
    .REGION_UNITS (REGION_UNITS)
  ) u_heads (
    .clk     (clk),
    .clear   (heads_clear),
    .wr_en   (heads_we),
    .wr_k    (heads_wk),
    .wr_data (heads_wd),
    .rd_k    (heads_rk),
    .rd_data (heads_rd)
  );

  // helper values
  logic [31:0]       units32, b32, bud32;
  logic [LINK_W-1:0] units;
  logic [AW-1:0]     lo, hi;
  logic [USED_W-1:0] term_k, term_t;
  logic [JW-1:0]     t_k;

  always_comb begin
    units32 = 32'(region >> MIN_ORDER_LOG);
    units   = (units32 > 32'(REGION_UNITS)) ? NIL : LINK_W'(units32);
    b32     = 32'(off) - 32'(HEADER_BYTES);
    bud32   = 32'(u) ^ (32'd1 << k);
    lo      = (u < bud) ? u : bud;
    hi      = (u < bud) ? bud : u;
    t_k     = JW'(32'(tag_rd[TAG_ORDER_W-1:0]) - 32'd1);
    term_k  = (USED_W'(1) << (32'(k) + MIN_ORDER_LOG)) - USED_W'(HEADER_BYTES);
    term_t  = (USED_W'(1) << (32'(t_k) + MIN_ORDER_LOG)) - USED_W'(HEADER_BYTES);
  end

  // memory and head table write strobes and read addresses
  always_comb begin
    next_we = 1'b0; next_wa = pu; next_wd = heads_rd;
    prev_we = 1'b0; prev_wa = pu; prev_wd = NIL;
    tag_we  = 1'b0; tag_wa  = pu; tag_wd  = {1'b1, TAG_ORDER_W'(32'(pk) + 32'd1)};
    heads_clear = 1'b0;
    heads_we = 1'b0; heads_wk = pk[OW-1:0]; heads_wd = LINK_W'(pu);
    heads_rk = (state == S_PUSH0) ? pk[OW-1:0] : j[OW-1:0];
    tag_ra   = (state == S_F_BUD_RD) ? bud : u;
    unique case (state)
      S_CLEAR: begin
        tag_we = 1'b1; tag_wa = clr_idx; tag_wd = '0;
        heads_clear = 1'b1;
      end
      S_PUSH0: begin
        next_we = 1'b1; prev_we = 1'b1; tag_we = 1'b1; heads_we = 1'b1;
      end
      S_PUSH1: begin
        prev_we = 1'b1; prev_wa = ph[AW-1:0]; prev_wd = LINK_W'(pu);
      end
      S_RM1: begin
        if (prev_rd != NIL) begin
          next_we = 1'b1; next_wa = prev_rd[AW-1:0]; next_wd = next_rd;
        end else begin
          heads_we = 1'b1; heads_wk = rk[OW-1:0]; heads_wd = next_rd;
        end
        if (next_rd != NIL) begin
          prev_we = 1'b1; prev_wa = next_rd[AW-1:0]; prev_wd = prev_rd;
        end
      end
      S_A_DONE: begin
        tag_we = 1'b1; tag_wa = u; tag_wd = {1'b0, TAG_ORDER_W'(32'(k) + 32'd1)};
      end
      S_F_MERGE: begin
        tag_we = 1'b1; tag_wa = hi; tag_wd = '0;
      end
      default: begin
      end
    endcase
  end

  // result handed to the output register
  assign rsp_load = (state == S_DONE) && (!ov || rsp.ready);

  // sequencer and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      ret     <= S_IDLE;
      region  <= REGION_RESET;
      clr_idx <= '0;
      ov      <= 1'b0;
      count   <= '0;
      used    <= '0;
    end else begin
      if (rsp_load) ov <= 1'b1;
      else if (rsp.ready) ov <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == AW'(REGION_UNITS - 1)) begin
            state  <= S_CARVE;
            pos    <= '0;
            rem    <= units;
            carved <= units;
            count  <= '0;
            used   <= '0;
            k      <= TOP_K;
          end
        end
        S_CARVE: begin
          if (rem == '0) begin
            state <= S_IDLE;
          end else if (k != '0 && (32'd1 << k) > 32'(rem)) begin
            k <= k - 1'b1;
          end else begin
            pu    <= pos[AW-1:0];
            pk    <= k;
            pos   <= LINK_W'(32'(pos) + (32'd1 << k));
            rem   <= LINK_W'(32'(rem) - (32'd1 << k));
            k     <= TOP_K;
            ret   <= S_CARVE;
            state <= S_PUSH0;
          end
        end
        S_IDLE: begin
          if (cfg_wr_en) begin
            region  <= cfg_wr_data;
            clr_idx <= '0;
            state   <= S_CLEAR;
          end else if (req.valid) begin
            res_granted <= '0;
            off         <= req.user_offset;
            if (req.kind) begin
              state <= S_F_CHK;
            end else if (req.request_bytes == '0) begin
              res_status <= STATUS_ZERO;
              state      <= S_DONE;
            end else begin
              s     <= ((REQ_W+1)'(req.request_bytes) + (REQ_W+1)'(HEADER_BYTES) - 1'b1)
                       >> MIN_ORDER_LOG;
              k     <= '0;
              state <= S_A_SIZE;
            end
          end
        end
        // round the request up to an order
        S_A_SIZE: begin
          if (s == '0) begin
            j     <= k;
            state <= S_A_FIND;
          end else if (k == TOP_K) begin
            res_status <= STATUS_TOO_LARGE;
            state      <= S_DONE;
          end else begin
            s <= s >> 1;
            k <= k + 1'b1;
          end
        end
        // smallest nonempty list at or above the order
        S_A_FIND: begin
          if (j == K_END) begin
            res_status <= STATUS_NO_MEM;
            state      <= S_DONE;
          end else if (heads_rd != NIL) begin
            state <= S_A_SPLIT;
          end else begin
            j <= j + 1'b1;
          end
        end
        S_A_SPLIT: begin
          u     <= heads_rd[AW-1:0];
          ru    <= heads_rd[AW-1:0];
          rk    <= j;
          ret   <= (j > k) ? S_A_SPLIT_LO : S_A_DONE;
          state <= S_RM0;
        end
        S_A_SPLIT_LO: begin
          j     <= j - 1'b1;
          pu    <= u;
          pk    <= j - 1'b1;
          ret   <= S_A_SPLIT_HI;
          state <= S_PUSH0;
        end
        S_A_SPLIT_HI: begin
          pu    <= AW'(32'(u) + (32'd1 << j));
          pk    <= j;
          ret   <= S_A_SPLIT;
          state <= S_PUSH0;
        end
        S_A_DONE: begin
          count       <= count + 1'b1;
          used        <= used + term_k;
          res_granted <= OFFSET_W'((32'(u) << MIN_ORDER_LOG) + 32'(HEADER_BYTES));
          res_status  <= STATUS_OK;
          state       <= S_DONE;
        end
        // free: validate the address
        S_F_CHK: begin
          if (32'(off) < 32'(HEADER_BYTES) ||
              (b32 & ((32'd1 << MIN_ORDER_LOG) - 32'd1)) != 32'd0 ||
              (b32 >> MIN_ORDER_LOG) >= 32'(carved)) begin
            res_status <= STATUS_NOT_ALLOC;
            state      <= S_DONE;
          end else begin
            u     <= AW'(b32 >> MIN_ORDER_LOG);
            state <= S_F_RDTAG;
          end
        end
        S_F_RDTAG: state <= S_F_TAG;
        S_F_TAG: begin
          if (tag_rd[TAG_ORDER_W-1:0] == '0 || tag_rd[TAG_FREE_BIT] ||
              32'(tag_rd[TAG_ORDER_W-1:0]) > 32'(ORDER_COUNT)) begin
            res_status <= STATUS_NOT_ALLOC;
            state      <= S_DONE;
          end else begin
            res_status <= STATUS_OK;
            k     <= t_k;
            count <= count - 1'b1;
            used  <= used - term_t;
            pu    <= u;
            pk    <= t_k;
            ret   <= S_F_BUD;
            state <= S_PUSH0;
          end
        end
        // merge with the buddy while it is free at the same order
        S_F_BUD: begin
          if (k >= TOP_K || bud32 >= 32'(carved)) begin
            state <= S_DONE;
          end else begin
            bud   <= AW'(bud32);
            state <= S_F_BUD_RD;
          end
        end
        S_F_BUD_RD: state <= S_F_BUDCHK;
        S_F_BUDCHK: begin
          if (tag_rd != {1'b1, TAG_ORDER_W'(32'(k) + 32'd1)}) begin
            state <= S_DONE;
          end else begin
            ru    <= u;
            rk    <= k;
            ret   <= S_F_RM_BUD;
            state <= S_RM0;
          end
        end
        S_F_RM_BUD: begin
          ru    <= bud;
          rk    <= k;
          ret   <= S_F_MERGE;
          state <= S_RM0;
        end
        S_F_MERGE: begin
          pu    <= lo;
          pk    <= k + 1'b1;
          u     <= lo;
          k     <= k + 1'b1;
          ret   <= S_F_BUD;
          state <= S_PUSH0;
        end
        // list push at the head
        S_PUSH0: begin
          ph    <= heads_rd;
          state <= (heads_rd != NIL) ? S_PUSH1 : ret;
        end
        S_PUSH1: state <= ret;
        // list unlink, links read in S_RM0 and rewritten in S_RM1
        S_RM0: state <= S_RM1;
        S_RM1: state <= ret;
        S_DONE: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic [COUNT_W-1:0]  out_count;
  logic [USED_W-1:0]   out_used;
  status_t             out_status;
  logic [OFFSET_W-1:0] out_granted;

  // response payload captured when the result is handed over
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      out_status  <= res_status;
      out_granted <= res_granted;
      out_count   <= count;
      out_used    <= used;
    end
  end

  assign req.ready            = (state == S_IDLE) && !cfg_wr_en;
  assign rsp.valid            = ov;
  assign rsp.status           = out_status;
  assign rsp.granted_offset   = out_granted;
  assign rsp.allocated_blocks = out_count;
  assign rsp.used_bytes       = out_used;

  // checks
  `BBA_ASSERT_NEXT(a_busy_after_accept, clk, rst, req.valid && req.ready, !req.ready, "ready after accept")
  `BBA_ASSERT_NEXT(a_busy_after_cfg, clk, rst, cfg_wr_en && state == S_IDLE, state == S_CLEAR, "no re-carve")
  `BBA_ASSERT_NOW(a_grant_only_ok, clk, rst, rsp.valid && rsp.status != STATUS_OK, rsp.granted_offset == '0, "stray grant")

endmodule
